// ===== rtl/lltr_pkg.sv =====
// Shared constants and request encodings for the LFU/LRU replacement block.
`timescale 1ns / 1ps
`default_nettype none

package lltr_pkg;

    localparam int SETS_DEF       = 64;
    localparam int WAYS_DEF       = 8;
    localparam int COUNT_BITS_DEF = 16;

    localparam int TIME_W   = 32;
    localparam int OP_W     = 2;
    localparam int SET_IN_W = 6;
    localparam int WAY_IN_W = 3;
    localparam int USES_W   = 16;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    localparam logic [OP_W-1:0] OP_INVAL = 2'd0;
    localparam logic [OP_W-1:0] OP_TOUCH = 2'd1;
    localparam logic [OP_W-1:0] OP_FILL  = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/lltr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lltr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lltr_scan.sv =====
// Victim search: walks the ways of one set row, one way per cycle.
`timescale 1ns / 1ps
`default_nettype none

module lltr_scan
    import lltr_pkg::*;
#(
    parameter int WAYS       = WAYS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1,
    parameter int ENT_W      = COUNT_BITS + TIME_W
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic [WAYS*ENT_W-1:0]   row,
    output logic                         done,
    output logic      [WAY_W-1:0]        best_way,
    output logic      [COUNT_BITS-1:0]   best_count
);

    localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);

    logic                  active_reg, active_next;
    logic                  done_reg, done_next;
    logic [WAY_W-1:0]      idx_reg, idx_next;
    logic [WAY_W-1:0]      bway_reg, bway_next;
    logic [COUNT_BITS-1:0] bcnt_reg, bcnt_next;
    logic [TIME_W-1:0]     btime_reg, btime_next;

    logic [ENT_W-1:0]      ent;
    logic [COUNT_BITS-1:0] ent_cnt;
    logic [TIME_W-1:0]     ent_time;
    logic                  better;

    always_comb begin
        ent      = row[idx_reg*ENT_W +: ENT_W];
        ent_cnt  = ent[COUNT_BITS-1:0];
        ent_time = ent[ENT_W-1:COUNT_BITS];
        better   = (idx_reg == '0) || (ent_cnt < bcnt_reg) ||
                   ((ent_cnt == bcnt_reg) && (ent_time < btime_reg));

        active_next = active_reg;
        done_next   = 1'b0;
        idx_next    = idx_reg;
        bway_next   = bway_reg;
        bcnt_next   = bcnt_reg;
        btime_next  = btime_reg;

        if (start) begin
            active_next = 1'b1;
            idx_next    = '0;
        end else if (active_reg) begin
            if (better) begin
                bway_next  = idx_reg;
                bcnt_next  = ent_cnt;
                btime_next = ent_time;
            end
            if (idx_reg == LAST_WAY) begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            idx_reg    <= '0;
        end else begin
            active_reg <= active_next;
            done_reg   <= done_next;
            idx_reg    <= idx_next;
        end
        bway_reg  <= bway_next;
        bcnt_reg  <= bcnt_next;
        btime_reg <= btime_next;
    end

    assign done       = done_reg;
    assign best_way   = bway_reg;
    assign best_count = bcnt_reg;

endmodule

`default_nettype wire

// ===== rtl/lfu_lru_tiebreak_replacement.sv =====
// Top level: request decode, set-row read-modify-write and result register.
//
// LFU replacement with LRU tie-break. All ways of a set live in one memory
// row (count and 32-bit time per way). After reset a clearing pass zeroes
// the memory one set at a time, during which no request is taken.
// Invalidate, touch and fill read the row, then write the modified row back;
// if their set or way is out of range, the request is dropped. A victim query
// reads the row, starts the search, walks the ways in turn, finishes the
// search and loads the result register. A query for a set out of range
// skips the search and loads a zero result. A query also waits while the
// output register still holds a result the receiver has not taken. One
// request is in flight at a time; the result sits in an output register so
// the next request may enter while it waits.
`timescale 1ns / 1ps
`default_nettype none

module lfu_lru_tiebreak_replacement
    import lltr_pkg::*;
#(
    parameter int SETS       = SETS_DEF,
    parameter int WAYS       = WAYS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // opcode[1:0], set_index[7:2], way_index[10:8], now[42:11], zero fill
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // victim_way[2:0], victim_uses[18:3], zero fill
    output logic      [M_TDATA_W-1:0] m_tdata
);

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENT_W = COUNT_BITS + TIME_W;
    localparam int ROW_W = WAYS * ENT_W;

    localparam logic [SET_W-1:0]      LAST_SET  = SET_W'(SETS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RMW   = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [SET_W-1:0]      clr_reg, clr_next;
    logic [OP_W-1:0]       op_reg, op_next;
    logic [SET_W-1:0]      set_reg, set_next;
    logic [WAY_W-1:0]      way_reg, way_next;
    logic [TIME_W-1:0]     now_reg, now_next;
    logic                  zero_reg, zero_next;
    logic                  m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;

    logic [OP_W-1:0]       in_op;
    logic [31:0]           in_set_ext;
    logic [31:0]           in_way_ext;
    logic [TIME_W-1:0]     in_now;
    logic                  set_ok;
    logic                  way_ok;
    logic                  accept;

    logic                  ram_we;
    logic [SET_W-1:0]      ram_waddr;
    logic [ROW_W-1:0]      ram_wdata;
    logic                  ram_re;
    logic [ROW_W-1:0]      ram_rdata;
    logic [ROW_W-1:0]      row_mod;

    logic [ENT_W-1:0]      old_ent;
    logic [COUNT_BITS-1:0] old_cnt;
    logic [COUNT_BITS-1:0] new_cnt;
    logic [TIME_W-1:0]     new_time;

    logic                  scan_start;
    logic                  scan_done;
    logic [WAY_W-1:0]      scan_way;
    logic [COUNT_BITS-1:0] scan_count;
    logic [31:0]           res_way_ext;
    logic [31:0]           res_cnt_ext;
    logic                  out_free;

    assign in_op      = s_tdata[1:0];
    assign in_set_ext = 32'(s_tdata[7:2]);
    assign in_way_ext = 32'(s_tdata[10:8]);
    assign in_now     = s_tdata[42:11];
    assign set_ok     = in_set_ext < 32'(SETS);
    assign way_ok     = in_way_ext < 32'(WAYS);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // row update for invalidate / touch / fill
    always_comb begin
        old_ent = ram_rdata[way_reg*ENT_W +: ENT_W];
        old_cnt = old_ent[COUNT_BITS-1:0];
        unique case (op_reg)
            OP_INVAL: begin
                new_cnt  = '0;
                new_time = '0;
            end
            OP_TOUCH: begin
                new_cnt  = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + 1'b1;
                new_time = now_reg;
            end
            OP_FILL: begin
                new_cnt  = COUNT_BITS'(1);
                new_time = now_reg;
            end
            default: begin
                new_cnt  = old_cnt;
                new_time = old_ent[ENT_W-1:COUNT_BITS];
            end
        endcase
        row_mod = ram_rdata;
        row_mod[way_reg*ENT_W +: ENT_W] = {new_time, new_cnt};
    end

    assign res_way_ext = zero_reg ? 32'd0 : 32'(scan_way);
    assign res_cnt_ext = zero_reg ? 32'd0 : 32'(scan_count);

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        op_next      = op_reg;
        set_next     = set_reg;
        way_next     = way_reg;
        now_next     = now_reg;
        zero_next    = zero_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;

        ram_we     = 1'b0;
        ram_waddr  = set_reg;
        ram_wdata  = row_mod;
        ram_re     = 1'b0;
        scan_start = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_SET) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    op_next   = in_op;
                    set_next  = in_set_ext[SET_W-1:0];
                    way_next  = in_way_ext[WAY_W-1:0];
                    now_next  = in_now;
                    zero_next = !set_ok;
                    if (in_op == OP_QUERY) begin
                        ram_re     = set_ok;
                        state_next = set_ok ? ST_RMW : ST_EMIT;
                    end else if (set_ok && way_ok) begin
                        ram_re     = 1'b1;
                        state_next = ST_RMW;
                    end
                end
            end
            ST_RMW: begin
                if (op_reg == OP_QUERY) begin
                    scan_start = 1'b1;
                    state_next = ST_SCAN;
                end else begin
                    ram_we     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_TDATA_W'({res_cnt_ext[USES_W-1:0],
                                               res_way_ext[WAY_IN_W-1:0]});
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg     <= op_next;
        set_reg    <= set_next;
        way_reg    <= way_next;
        now_reg    <= now_next;
        zero_reg   <= zero_next;
        m_data_reg <= m_data_next;
    end

    lltr_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS),
        .ADDR_W(SET_W)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(in_set_ext[SET_W-1:0]),
        .rdata(ram_rdata)
    );

    lltr_scan #(
        .WAYS      (WAYS),
        .COUNT_BITS(COUNT_BITS),
        .WAY_W     (WAY_W),
        .ENT_W     (ENT_W)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (scan_start),
        .row       (ram_rdata),
        .done      (scan_done),
        .best_way  (scan_way),
        .best_count(scan_count)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_done_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_done |-> (state_reg == ST_SCAN))
        else $error("search finished outside scan state");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !ram_we)
        else $error("memory written while a search reads the row");

    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_EMIT))
        else $error("result raised without a query");

    a_read_only_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_re |-> accept)
        else $error("row read without an accepted request");

endmodule

`default_nettype wire
